// ----- sv/sdsh_pkg.sv -----
// ----------------------------------------------------------------------------
// sdsh_pkg
// Shared types and constants of the SD-card SPI host sequencer.
// ----------------------------------------------------------------------------
package sdsh_pkg;

    localparam logic [1:0] KIND_REQ   = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    localparam logic [1:0] REG_POLL   = 2'd0;
    localparam logic [1:0] REG_RESP   = 2'd1;
    localparam logic [1:0] REG_WAKE   = 2'd2;
    localparam logic [1:0] REG_SETTLE = 2'd3;

    // One item as it travels from the front part to the back part.
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  request;
        logic [31:0] sector;
        logic [7:0]  rx_byte;
        logic [7:0]  wr_byte;
    } sdsh_item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       chip_select;
        logic       fast_clock;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       need_data;
        logic       done_res;
        logic [1:0] status;
        logic [2:0] card_kind;
    } sdsh_result_t;

    // Configuration registers as seen by the back part.
    typedef struct packed {
        logic [15:0] poll_limit;
        logic [7:0]  response_limit;
        logic [7:0]  wake_bytes;
        logic [9:0]  settle_ticks;
    } sdsh_cfg_t;

    // One CRC7 step over a whole byte; eight dependent one-bit steps.
    function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] b_in);
        logic [6:0] c;
        logic [7:0] b;
        logic       fb;
        c = crc_in;
        b = b_in;
        for (int i = 0; i < 8; i++) begin
            fb = b[7] ^ c[6];
            c  = {c[5:0], 1'b0} ^ (fb ? 7'h09 : 7'h00);
            b  = {b[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- sv/sdsh_queue.sv -----
// ----------------------------------------------------------------------------
// sdsh_queue
// Two-entry item queue between the front and back parts.
// ----------------------------------------------------------------------------
module sdsh_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sdsh_pkg::sdsh_item_t in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output sdsh_pkg::sdsh_item_t out_item
);
    import sdsh_pkg::*;

    sdsh_item_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_stall  = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;

    // Both entries start cleared so that the back part never decodes an
    // unknown item while the queue is empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_reg <= '{default: '0};
        end
        else if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 && !pop |=> count_reg == 2'd2)
        else $error("queue count lost");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue overflow");
    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd0 && push |=> out_valid)
        else $error("pushed item not visible");

endmodule

// ----- sv/sdsh_engine.sv -----
// ----------------------------------------------------------------------------
// sdsh_engine
// Back part: registers card protocol results, one item per unstalled cycle.
// ----------------------------------------------------------------------------
module sdsh_engine #(
    parameter int BLOCK_BYTES = 512
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sdsh_pkg::sdsh_cfg_t   cfg,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  sdsh_pkg::sdsh_item_t  item,
    output logic                  res_valid,
    input  logic                  res_stall,
    output sdsh_pkg::sdsh_result_t res
);
    import sdsh_pkg::*;

    localparam int BW = $clog2(BLOCK_BYTES + 1);

    typedef enum logic [4:0] {
        PH_IDLE, PH_WAKE, PH_SEL, PH_SEL_WAIT, PH_PRE, PH_FRAME, PH_RESP,
        PH_SETTLE, PH_OCR, PH_TOKEN, PH_RDATA, PH_RCRC, PH_WSPACE, PH_WTOKEN,
        PH_WNEED, PH_WDATA, PH_WCRC, PH_WRESP, PH_REL
    } phase_t;

    typedef enum logic [3:0] {
        K_IDLE, K_IFCOND, K_OP41_HC, K_OCR, K_OP41_FIRST, K_OP41, K_OP1,
        K_BLOCKLEN, K_READ, K_WRITE
    } cont_t;

    typedef enum logic [1:0] { OP_INIT, OP_READ, OP_WRITE, OP_SYNC } op_t;

    localparam logic [2:0] KD_NONE = 3'd0, KD_MMC = 3'd1, KD_SD1 = 3'd2,
                           KD_SD2 = 3'd3, KD_SDHC = 3'd4;
    localparam logic [1:0] ST_OK = 2'd0, ST_ERR = 2'd1, ST_NRDY = 2'd2, ST_BAD = 2'd3;

    phase_t      phase_reg, phase_next;
    cont_t       cont_reg, cont_next;
    op_t         op_reg, op_next;
    logic [2:0]  kind_reg, kind_next, found_reg, found_next;
    logic [6:0]  code_reg, code_next, crc_reg, crc_next;
    logic [31:0] arg_reg, arg_next, ocr_reg, ocr_next;
    logic [2:0]  fidx_reg, fidx_next;
    logic [15:0] wait_reg, wait_next;
    logic [BW-1:0] bcnt_reg, bcnt_next;
    logic [9:0]  tick_reg, tick_next;
    logic [1:0]  app_reg, app_next, fst_reg, fst_next;
    logic        cs_reg, cs_next, fast_reg, fast_next;
    logic        res_valid_reg;
    sdsh_result_t res_reg, r;
    logic        emit;
    logic        take;

    logic [15:0] poll_eff;
    logic [7:0]  resp_eff, wake_eff;

    assign poll_eff = (cfg.poll_limit == 16'd0) ? 16'd1 : cfg.poll_limit;
    assign resp_eff = (cfg.response_limit == 8'd0) ? 8'd1 : cfg.response_limit;
    assign wake_eff = (cfg.wake_bytes == 8'd0) ? 8'd1 : cfg.wake_bytes;

    assign item_stall = res_valid_reg && res_stall;
    assign take       = item_valid && !item_stall;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    always_comb
    begin
        logic [7:0]  rx;
        logic [31:0] a, fa;
        logic [6:0]  fc;
        logic [7:0]  fb;
        logic [15:0] winc;
        logic        go_frame, go_send, go_cmd, go_rel, go_endinit;
        logic [6:0]  c_code;
        logic [31:0] c_arg;
        cont_t       c_k;
        logic [7:0]  s_byte;
        phase_t      s_ph;
        logic [1:0]  rel_st;

        phase_next = phase_reg; cont_next = cont_reg; op_next = op_reg;
        kind_next = kind_reg; found_next = found_reg; code_next = code_reg;
        crc_next = crc_reg; arg_next = arg_reg; ocr_next = ocr_reg;
        fidx_next = fidx_reg; wait_next = wait_reg; bcnt_next = bcnt_reg;
        tick_next = tick_reg; app_next = app_reg; fst_next = fst_reg;
        cs_next = cs_reg; fast_next = fast_reg;
        rx = item.rx_byte;
        winc = (wait_reg < 16'hFFFF) ? wait_reg + 16'd1 : wait_reg;
        emit = 1'b0;
        r = '0;
        go_frame = 1'b0; go_send = 1'b0; go_cmd = 1'b0; go_rel = 1'b0;
        go_endinit = 1'b0;
        c_code = '0; c_arg = '0; c_k = K_IDLE;
        s_byte = 8'hFF; s_ph = PH_IDLE; rel_st = ST_OK;
        a = '0; fa = '0; fc = '0; fb = '0;

        unique case (item.kind)
            KIND_REQ:
            begin
                emit = 1'b1;
                if (phase_reg != PH_IDLE)
                begin
                    r.done_res = 1'b1; r.status = ST_BAD;
                end
                else if (item.request == 2'(OP_INIT))
                begin
                    op_next = OP_INIT; found_next = KD_NONE;
                    cs_next = 1'b0; fast_next = 1'b0;
                    bcnt_next = BW'(1);
                    go_send = 1'b1; s_ph = PH_WAKE;
                end
                else if (kind_reg == KD_NONE)
                begin
                    r.done_res = 1'b1; r.status = ST_NRDY;
                end
                else
                begin
                    op_next = op_t'(item.request);
                    arg_next = item.sector;
                    cs_next = 1'b1; wait_next = '0;
                    go_send = 1'b1; s_ph = PH_SEL;
                end
            end
            KIND_WRITE:
            begin
                if (phase_reg == PH_WNEED)
                begin
                    emit = 1'b1; go_send = 1'b1; s_byte = item.wr_byte; s_ph = PH_WDATA;
                end
            end
            KIND_TICK:
            begin
                if (phase_reg == PH_SEL_WAIT)
                begin
                    emit = 1'b1;
                    if (wait_reg >= poll_eff)
                    begin
                        go_rel = 1'b1; rel_st = ST_ERR;
                    end
                    else
                    begin
                        go_send = 1'b1; s_ph = PH_SEL;
                    end
                end
                else if (phase_reg == PH_SETTLE)
                begin
                    logic [9:0] t;
                    t = (tick_reg < cfg.settle_ticks) ? tick_reg + 10'd1 : tick_reg;
                    tick_next = t;
                    if (t >= cfg.settle_ticks)
                    begin
                        emit = 1'b1; fast_next = 1'b1;
                        go_cmd = 1'b1; c_code = 7'd8; c_arg = 32'h1AA; c_k = K_IFCOND;
                    end
                end
            end
            default:
            begin
                unique case (phase_reg)
                    PH_WAKE:
                    begin
                        emit = 1'b1;
                        if (bcnt_reg < BW'(wake_eff))
                        begin
                            bcnt_next = bcnt_reg + BW'(1);
                            go_send = 1'b1; s_ph = PH_WAKE;
                        end
                        else
                        begin
                            cs_next = 1'b1; wait_next = '0;
                            go_send = 1'b1; s_ph = PH_SEL;
                        end
                    end
                    PH_SEL:
                    begin
                        if (rx == 8'hFF)
                        begin
                            emit = 1'b1;
                            a = (kind_reg != KD_SDHC) ? {arg_reg[22:0], 9'd0} : arg_reg;
                            unique case (op_reg)
                                OP_INIT:  begin go_cmd = 1'b1; c_code = 7'd0; c_k = K_IDLE; end
                                OP_READ:  begin go_cmd = 1'b1; c_code = 7'd17; c_arg = a; c_k = K_READ; end
                                OP_WRITE: begin go_cmd = 1'b1; c_code = 7'd24; c_arg = a; c_k = K_WRITE; end
                                default:  begin go_rel = 1'b1; rel_st = ST_OK; end
                            endcase
                        end
                        else
                        begin
                            wait_next = winc; phase_next = PH_SEL_WAIT;
                        end
                    end
                    PH_PRE:
                    begin
                        emit = 1'b1;
                        if (app_reg == 2'd1)
                        begin
                            app_next = 2'd2; go_send = 1'b1; s_ph = PH_PRE;
                        end
                        else go_frame = 1'b1;
                    end
                    PH_FRAME:
                    begin
                        emit = 1'b1;
                        if (fidx_reg < 3'd5)
                        begin
                            fidx_next = fidx_reg + 3'd1; go_frame = 1'b1;
                        end
                        else
                        begin
                            bcnt_next = BW'(1); go_send = 1'b1; s_ph = PH_RESP;
                        end
                    end
                    PH_RESP:
                    begin
                        emit = 1'b1;
                        if (rx == 8'hFF && bcnt_reg < BW'(resp_eff))
                        begin
                            bcnt_next = bcnt_reg + BW'(1); go_send = 1'b1; s_ph = PH_RESP;
                        end
                        else if (app_reg == 2'd2 && rx <= 8'd1)
                        begin
                            app_next = 2'd0; fidx_next = '0; crc_next = '0; go_frame = 1'b1;
                        end
                        else
                        begin
                            if (app_reg == 2'd2) app_next = 2'd0;
                            unique case (cont_reg)
                                K_IDLE:
                                begin
                                    if (rx <= 8'd1)
                                    begin
                                        tick_next = '0;
                                        if (cfg.settle_ticks == 10'd0)
                                        begin
                                            fast_next = 1'b1; go_cmd = 1'b1;
                                            c_code = 7'd8; c_arg = 32'h1AA; c_k = K_IFCOND;
                                        end
                                        else
                                        begin
                                            emit = 1'b0; phase_next = PH_SETTLE;
                                        end
                                    end
                                    else
                                    begin
                                        found_next = KD_NONE; go_endinit = 1'b1;
                                    end
                                end
                                K_IFCOND:
                                begin
                                    if (rx <= 8'd1)
                                    begin
                                        fidx_next = '0; ocr_next = '0;
                                        go_send = 1'b1; s_ph = PH_OCR;
                                    end
                                    else
                                    begin
                                        go_cmd = 1'b1; c_code = 7'h69; c_k = K_OP41_FIRST;
                                    end
                                end
                                K_OP41_HC:
                                begin
                                    wait_next = winc;
                                    if (rx == 8'd0)
                                    begin
                                        go_cmd = 1'b1; c_code = 7'd58; c_k = K_OCR;
                                    end
                                    else if (winc >= poll_eff)
                                    begin
                                        found_next = KD_NONE; go_endinit = 1'b1;
                                    end
                                    else
                                    begin
                                        go_cmd = 1'b1; c_code = 7'h69;
                                        c_arg = 32'h4000_0000; c_k = K_OP41_HC;
                                    end
                                end
                                K_OCR:
                                begin
                                    if (rx == 8'd0)
                                    begin
                                        fidx_next = '0; ocr_next = '0;
                                        go_send = 1'b1; s_ph = PH_OCR;
                                    end
                                    else
                                    begin
                                        found_next = KD_NONE; go_endinit = 1'b1;
                                    end
                                end
                                K_OP41_FIRST:
                                begin
                                    wait_next = '0; go_cmd = 1'b1;
                                    if (rx <= 8'd1)
                                    begin
                                        c_code = 7'h69; c_k = K_OP41;
                                    end
                                    else
                                    begin
                                        c_code = 7'd1; c_k = K_OP1;
                                    end
                                end
                                K_OP41, K_OP1:
                                begin
                                    wait_next = winc;
                                    if (rx == 8'd0)
                                    begin
                                        found_next = (cont_reg == K_OP41) ? KD_SD1 : KD_MMC;
                                        go_endinit = 1'b1;
                                    end
                                    else if (winc >= poll_eff)
                                    begin
                                        found_next = KD_NONE; go_endinit = 1'b1;
                                    end
                                    else
                                    begin
                                        go_cmd = 1'b1; c_k = cont_reg;
                                        c_code = (cont_reg == K_OP41) ? 7'h69 : 7'd1;
                                    end
                                end
                                K_BLOCKLEN:
                                begin
                                    go_rel = 1'b1; rel_st = ST_OK;
                                end
                                K_READ:
                                begin
                                    if (rx == 8'd0)
                                    begin
                                        wait_next = '0; go_send = 1'b1; s_ph = PH_TOKEN;
                                    end
                                    else
                                    begin
                                        go_rel = 1'b1; rel_st = ST_ERR;
                                    end
                                end
                                default:
                                begin
                                    if (rx == 8'd0)
                                    begin
                                        go_send = 1'b1; s_ph = PH_WSPACE;
                                    end
                                    else
                                    begin
                                        go_rel = 1'b1; rel_st = ST_ERR;
                                    end
                                end
                            endcase
                        end
                    end
                    PH_OCR:
                    begin
                        logic [31:0] o;
                        emit = 1'b1;
                        o = {ocr_reg[23:0], rx};
                        ocr_next = o;
                        fidx_next = fidx_reg + 3'd1;
                        if (fidx_reg + 3'd1 < 3'd4)
                        begin
                            go_send = 1'b1; s_ph = PH_OCR;
                        end
                        else if (cont_reg == K_IFCOND)
                        begin
                            if (o[15:8] == 8'h01 && o[7:0] == 8'hAA)
                            begin
                                wait_next = '0; go_cmd = 1'b1; c_code = 7'h69;
                                c_arg = 32'h4000_0000; c_k = K_OP41_HC;
                            end
                            else
                            begin
                                found_next = KD_NONE; go_endinit = 1'b1;
                            end
                        end
                        else
                        begin
                            found_next = o[30] ? KD_SDHC : KD_SD2; go_endinit = 1'b1;
                        end
                    end
                    PH_TOKEN:
                    begin
                        emit = 1'b1; wait_next = winc;
                        if (rx != 8'hFF)
                        begin
                            if (rx == 8'hFE)
                            begin
                                bcnt_next = '0; go_send = 1'b1; s_ph = PH_RDATA;
                            end
                            else
                            begin
                                go_rel = 1'b1; rel_st = ST_ERR;
                            end
                        end
                        else if (winc >= poll_eff)
                        begin
                            go_rel = 1'b1; rel_st = ST_ERR;
                        end
                        else
                        begin
                            go_send = 1'b1; s_ph = PH_TOKEN;
                        end
                    end
                    PH_RDATA:
                    begin
                        emit = 1'b1;
                        bcnt_next = bcnt_reg + BW'(1);
                        if (bcnt_reg + BW'(1) >= BW'(BLOCK_BYTES))
                        begin
                            fidx_next = '0; phase_next = PH_RCRC;
                        end
                        r.tx_byte = 8'hFF; r.tx_valid = 1'b1;
                        r.read_byte = rx; r.read_valid = 1'b1;
                    end
                    PH_RCRC, PH_WCRC:
                    begin
                        emit = 1'b1;
                        if (fidx_reg == 3'd0)
                        begin
                            fidx_next = 3'd1; go_send = 1'b1; s_ph = phase_reg;
                        end
                        else if (phase_reg == PH_RCRC)
                        begin
                            go_rel = 1'b1; rel_st = ST_OK;
                        end
                        else
                        begin
                            go_send = 1'b1; s_ph = PH_WRESP;
                        end
                    end
                    PH_WSPACE:
                    begin
                        emit = 1'b1; go_send = 1'b1; s_byte = 8'hFE; s_ph = PH_WTOKEN;
                    end
                    PH_WTOKEN:
                    begin
                        emit = 1'b1; bcnt_next = '0; phase_next = PH_WNEED;
                        r.need_data = 1'b1;
                    end
                    PH_WDATA:
                    begin
                        emit = 1'b1;
                        bcnt_next = bcnt_reg + BW'(1);
                        if (bcnt_reg + BW'(1) < BW'(BLOCK_BYTES))
                        begin
                            phase_next = PH_WNEED; r.need_data = 1'b1;
                        end
                        else
                        begin
                            fidx_next = '0; go_send = 1'b1; s_ph = PH_WCRC;
                        end
                    end
                    PH_WRESP:
                    begin
                        emit = 1'b1; go_rel = 1'b1;
                        rel_st = (rx[4:0] == 5'h05) ? ST_OK : ST_ERR;
                    end
                    PH_REL:
                    begin
                        emit = 1'b1;
                        if (op_reg == OP_INIT) kind_next = found_reg;
                        phase_next = PH_IDLE;
                        r.done_res = 1'b1; r.status = fst_reg;
                    end
                    default: ;
                endcase
            end
        endcase

        // End of detection: set the block length on byte-addressed cards.
        if (go_endinit)
        begin
            if (found_next == KD_MMC || found_next == KD_SD1 || found_next == KD_SD2)
            begin
                go_cmd = 1'b1; c_code = 7'd16; c_arg = 32'(BLOCK_BYTES); c_k = K_BLOCKLEN;
            end
            else
            begin
                go_rel = 1'b1; rel_st = (found_next != KD_NONE) ? ST_OK : ST_ERR;
            end
        end
        if (go_cmd)
        begin
            code_next = c_code; arg_next = c_arg; cont_next = c_k;
            app_next = c_code[6] ? 2'd1 : 2'd0;
            go_send = 1'b1; s_byte = 8'hFF; s_ph = PH_PRE;
        end
        if (go_rel)
        begin
            cs_next = 1'b0; fst_next = rel_st;
            go_send = 1'b1; s_byte = 8'hFF; s_ph = PH_REL;
        end
        if (go_frame)
        begin
            // fidx_next / crc_next hold the position and running CRC here.
            if (phase_reg == PH_PRE)
            begin
                fidx_next = '0; crc_next = '0;
            end
            fc = (app_next == 2'd2) ? 7'd55 : code_reg;
            fa = (app_next == 2'd2) ? 32'd0 : arg_reg;
            unique case (fidx_next)
                3'd0: fb = {1'b0, fc} | 8'h40;
                3'd1: fb = fa[31:24];
                3'd2: fb = fa[23:16];
                3'd3: fb = fa[15:8];
                3'd4: fb = fa[7:0];
                default: fb = {crc_next, 1'b1};
            endcase
            if (fidx_next < 3'd5) crc_next = crc7_byte(crc_next, fb);
            go_send = 1'b1; s_byte = fb; s_ph = PH_FRAME;
        end
        if (go_send)
        begin
            phase_next = s_ph;
            r.tx_byte = s_byte; r.tx_valid = 1'b1;
        end
        r.chip_select = cs_next;
        r.fast_clock  = fast_next;
        r.card_kind   = kind_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            res_reg <= r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; cont_reg <= K_IDLE; op_reg <= OP_INIT;
            kind_reg <= KD_NONE; found_reg <= KD_NONE; code_reg <= '0;
            crc_reg <= '0; arg_reg <= '0; ocr_reg <= '0; fidx_reg <= '0;
            wait_reg <= '0; bcnt_reg <= '0; tick_reg <= '0; app_reg <= '0;
            fst_reg <= '0; cs_reg <= 1'b0; fast_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next; cont_reg <= cont_next; op_reg <= op_next;
                kind_reg <= kind_next; found_reg <= found_next; code_reg <= code_next;
                crc_reg <= crc_next; arg_reg <= arg_next; ocr_reg <= ocr_next;
                fidx_reg <= fidx_next; wait_reg <= wait_next; bcnt_reg <= bcnt_next;
                tick_reg <= tick_next; app_reg <= app_next; fst_reg <= fst_next;
                cs_reg <= cs_next; fast_reg <= fast_next;
            end
            if (take)
                res_valid_reg <= emit;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_stall |=> res_valid_reg && $stable(res_reg))
        else $error("result lost under stall");
    a_rel_deselect: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_REL |-> !cs_reg)
        else $error("release with card selected");
    a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
        take && phase_reg == PH_REL && item.kind == KIND_REPLY |=> phase_reg == PH_IDLE)
        else $error("release did not finish");

endmodule

// ----- sv/sd_spi_host_sequencer.sv -----
// ----------------------------------------------------------------------------
// sd_spi_host_sequencer
// Byte-level SD-card SPI host: init/detection, sector read/write, sync.
// ----------------------------------------------------------------------------
// One item is taken per clock and each item gives at most one result item. An
// item (host request, card reply byte, host write byte or millisecond tick)
// enters a two-entry queue; the protocol engine behind it takes one item per
// cycle, updating its sequencer and the CRC7 of the command frame in that same
// cycle, and registers the result in an output stage. The engine keeps taking
// items while that stage is drained, and only stalls when a result is waiting
// and the output side stalls. Every byte sent with tx_valid must be answered
// by exactly one card reply item. Configuration is written through its own
// valid/ready port, always ready, and should only be written while idle.
// ----------------------------------------------------------------------------
module sd_spi_host_sequencer #(
    parameter int BLOCK_BYTES = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [1:0]  request,
    input  logic [31:0] sector,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  wr_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  tx_byte,
    output logic        tx_valid,
    output logic        chip_select,
    output logic        fast_clock,
    output logic [7:0]  read_byte,
    output logic        read_valid,
    output logic        need_data,
    output logic        done_res,
    output logic [1:0]  status,
    output logic [2:0]  card_kind
);
    import sdsh_pkg::*;

    sdsh_cfg_t    cfg_reg;
    sdsh_item_t   in_item, q_item;
    sdsh_result_t res;
    logic         q_valid, q_stall;

    // Front part: configuration registers and item capture.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_limit     <= 16'd50000;
            cfg_reg.response_limit <= 8'd10;
            cfg_reg.wake_bytes     <= 8'd10;
            cfg_reg.settle_ticks   <= 10'd250;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_POLL:   cfg_reg.poll_limit     <= cfg_data;
                REG_RESP:   cfg_reg.response_limit <= cfg_data[7:0];
                REG_WAKE:   cfg_reg.wake_bytes     <= cfg_data[7:0];
                default:    cfg_reg.settle_ticks   <= cfg_data[9:0];
            endcase
        end
    end

    assign in_item = '{kind: kind, request: request, sector: sector,
                       rx_byte: rx_byte, wr_byte: wr_byte};

    sdsh_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(q_valid), .out_stall(q_stall), .out_item(q_item)
    );

    sdsh_engine #(.BLOCK_BYTES(BLOCK_BYTES)) u_engine (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .item_valid(q_valid), .item_stall(q_stall), .item(q_item),
        .res_valid(out_valid), .res_stall(out_stall), .res(res)
    );

    assign tx_byte     = res.tx_byte;
    assign tx_valid    = res.tx_valid;
    assign chip_select = res.chip_select;
    assign fast_clock  = res.fast_clock;
    assign read_byte   = res.read_byte;
    assign read_valid  = res.read_valid;
    assign need_data   = res.need_data;
    assign done_res    = res.done_res;
    assign status      = res.status;
    assign card_kind   = res.card_kind;

    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> status == 2'd0)
        else $error("status without done");
    a_read_tx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_valid |-> tx_valid && tx_byte == 8'hFF)
        else $error("read data without filler byte");
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> card_kind <= 3'd4)
        else $error("bad card kind");

endmodule
